@@ hdl/fassd_pkg.sv @@
// ----------------------------------------------------------------------------
// fassd_pkg
// Types and constants shared by the flight auto start/stop detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fassd_pkg;

    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_TOGGLE     = 2'd1,
        KIND_RESET_STOP = 2'd2,
        KIND_UNUSED     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_AUTO_START_ENABLE = 3'd0,
        REG_AUTO_STOP_ENABLE  = 3'd1,
        REG_START_SPEED_MIN   = 3'd2,
        REG_START_TICKS       = 3'd3,
        REG_STOP_ALT_BAND     = 3'd4,
        REG_STOP_SPEED_MAX    = 3'd5,
        REG_STOP_ACCEL_BAND   = 3'd6,
        REG_STOP_TICKS        = 3'd7
    } reg_index_t;

    localparam int unsigned CFG_DATA_W = 23;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic signed [16:0] ONE_G = 17'sd1024;

    typedef struct packed {
        logic               summary_showing;
        logic               accel_valid;
        logic signed [15:0] accel;
        logic               baro_ready;
        logic signed [23:0] altitude;
        logic [15:0]        speed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] stop_ticks_left;
        logic       session_active;
        logic       alert_clear;
        logic       alert_raise;
        logic       session_stopped;
        logic       session_started;
    } out_item_t;

endpackage

`default_nettype wire

@@ hdl/flight_auto_start_stop_detector_unit.sv @@
// ----------------------------------------------------------------------------
// flight_auto_start_stop_detector_unit
// Decides when a flight session begins and ends from tick and manual events.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transaction per event. tuser carries the event
// kind (tick, manual toggle, reset of the auto-stop count); tdata carries the
// sensor readings of a tick. Output stream m_axis: exactly one transaction
// per input transaction, in order, with the start/stop/alert pulses, the
// session state after the event and the remaining calm ticks.
// Configuration: cfg_we writes cfg_data into register cfg_index.
// An accepted transaction goes into the input register; the decision logic
// then loads the output register from it when the output register is free.
// Throughput is one transaction per cycle while m_axis_tready is high;
// the decision logic and the session state update sit in a single register-to-register path.
// A stalled receiver holds the output register; the input register still
// drains into it once it empties, and s_axis_tready drops only while both are
// full and m_axis_tready is low.
// Reset clears the session state, both counters, the reference altitude, the
// alert flag, all configuration registers to their defaults and both valids.
// ----------------------------------------------------------------------------
`default_nettype none

module flight_auto_start_stop_detector_unit
    import fassd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // speed[15:0], altitude[39:16], baro_ready[40], accel[56:41],
    // accel_valid[57], summary_showing[58], zero[63:59]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // session_started[0], session_stopped[1], alert_raise[2], alert_clear[3],
    // session_active[4], stop_ticks_left[12:5], zero[15:13]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic        auto_start_enable_reg;
    logic        auto_stop_enable_reg;
    logic [15:0] start_speed_min_reg;
    logic [7:0]  start_ticks_reg;
    logic [22:0] stop_alt_band_reg;
    logic [15:0] stop_speed_max_reg;
    logic [14:0] stop_accel_band_reg;
    logic [7:0]  stop_ticks_reg;

    logic               running_reg, running_next;
    logic [7:0]         start_count_reg, start_count_next;
    logic [7:0]         stop_count_reg, stop_count_next;
    logic signed [23:0] ref_alt_reg, ref_alt_next;
    logic               alert_shown_reg, alert_shown_next;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    kind_t     in_kind_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg, out_item_next;
    logic      advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(out_item_t)){1'b0}}, out_item_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_start_enable_reg <= 1'b0;
            auto_stop_enable_reg  <= 1'b0;
            start_speed_min_reg   <= 16'd500;
            start_ticks_reg       <= 8'd10;
            stop_alt_band_reg     <= 23'd100;
            stop_speed_max_reg    <= 16'd300;
            stop_accel_band_reg   <= 15'd102;
            stop_ticks_reg        <= 8'd60;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_AUTO_START_ENABLE: auto_start_enable_reg <= cfg_data[0];
                REG_AUTO_STOP_ENABLE:  auto_stop_enable_reg  <= cfg_data[0];
                REG_START_SPEED_MIN:   start_speed_min_reg   <= cfg_data[15:0];
                REG_START_TICKS:       start_ticks_reg       <= cfg_data[7:0];
                REG_STOP_ALT_BAND:     stop_alt_band_reg     <= cfg_data[22:0];
                REG_STOP_SPEED_MAX:    stop_speed_max_reg    <= cfg_data[15:0];
                REG_STOP_ACCEL_BAND:   stop_accel_band_reg   <= cfg_data[14:0];
                REG_STOP_TICKS:        stop_ticks_reg        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= s_axis_tdata[$bits(in_item_t)-1:0];
            in_kind_reg <= kind_t'(s_axis_tuser);
        end
    end

    // Decision logic
    logic signed [24:0] alt_diff;
    logic [24:0]        alt_mag;
    logic signed [16:0] accel_diff;
    logic [16:0]        accel_mag;
    logic               calm;
    logic [7:0]         start_inc;
    logic [7:0]         stop_inc;

    always_comb
    begin
        alt_diff   = 25'(in_item_reg.altitude) - 25'(ref_alt_reg);
        alt_mag    = alt_diff[24] ? 25'(-alt_diff) : 25'(alt_diff);
        accel_diff = 17'(in_item_reg.accel) - ONE_G;
        accel_mag  = accel_diff[16] ? 17'(-accel_diff) : 17'(accel_diff);
        calm       = (alt_mag < {2'b00, stop_alt_band_reg})
                  && (in_item_reg.speed < stop_speed_max_reg)
                  && in_item_reg.accel_valid
                  && (accel_mag < {2'b00, stop_accel_band_reg});
        start_inc  = start_count_reg + 8'd1;
        stop_inc   = stop_count_reg + 8'd1;

        running_next     = running_reg;
        start_count_next = start_count_reg;
        stop_count_next  = stop_count_reg;
        ref_alt_next     = ref_alt_reg;
        alert_shown_next = alert_shown_reg;
        out_item_next    = '0;

        case (in_kind_reg)
            KIND_TICK:
            begin
                if (!running_reg)
                begin
                    if (auto_start_enable_reg)
                    begin
                        if (in_item_reg.summary_showing)
                        begin
                            start_count_next = 8'd0;
                        end
                        else if (in_item_reg.speed > start_speed_min_reg)
                        begin
                            start_count_next = start_inc;
                            if (start_inc >= start_ticks_reg)
                            begin
                                start_count_next              = 8'd0;
                                running_next                  = 1'b1;
                                out_item_next.session_started = 1'b1;
                            end
                        end
                        else
                        begin
                            start_count_next = 8'd0;
                        end
                    end
                end
                else if (auto_stop_enable_reg && in_item_reg.baro_ready)
                begin
                    if (calm)
                    begin
                        stop_count_next = stop_inc;
                        if (stop_inc == {1'b0, stop_ticks_reg[7:1]})
                        begin
                            alert_shown_next          = 1'b1;
                            out_item_next.alert_raise = 1'b1;
                        end
                        if (stop_inc >= stop_ticks_reg)
                        begin
                            stop_count_next = 8'd0;
                            if (alert_shown_next)
                            begin
                                alert_shown_next          = 1'b0;
                                out_item_next.alert_clear = 1'b1;
                            end
                            running_next                  = 1'b0;
                            out_item_next.session_stopped = 1'b1;
                        end
                    end
                    else
                    begin
                        stop_count_next = 8'd0;
                        if (alert_shown_reg)
                        begin
                            alert_shown_next          = 1'b0;
                            out_item_next.alert_clear = 1'b1;
                        end
                        ref_alt_next = in_item_reg.altitude;
                    end
                end
            end
            KIND_TOGGLE:
            begin
                running_next = !running_reg;
                if (running_reg)
                begin
                    out_item_next.session_stopped = 1'b1;
                end
                else
                begin
                    out_item_next.session_started = 1'b1;
                end
            end
            KIND_RESET_STOP:
            begin
                stop_count_next  = 8'd0;
                alert_shown_next = 1'b0;
            end
            default: ;
        endcase

        out_item_next.session_active  = running_next;
        out_item_next.stop_ticks_left = (stop_count_next != 8'd0)
                                      ? 8'(stop_ticks_reg - stop_count_next) : 8'd0;
    end

    // Session state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            start_count_reg <= 8'd0;
            stop_count_reg  <= 8'd0;
            ref_alt_reg     <= '0;
            alert_shown_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                running_reg     <= running_next;
                start_count_reg <= start_count_next;
                stop_count_reg  <= stop_count_next;
                ref_alt_reg     <= ref_alt_next;
                alert_shown_reg <= alert_shown_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_start_stop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.session_started && out_item_reg.session_stopped))
        else $error("session started and stopped on one transaction");

    a_started_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.session_started) |-> out_item_reg.session_active)
        else $error("session start reported without an active session");

    a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.session_stopped) |-> !out_item_reg.session_active)
        else $error("session stop reported with the session still active");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(running_reg) && $stable(stop_count_reg)
                      && $stable(start_count_reg)))
        else $error("session state changed without a transaction advancing");

endmodule

`default_nettype wire
